// ----- rtl/v4au_pkg.sv -----
// v4au_pkg: shared types, codes and helpers of the vec4 arithmetic unit
// no dependencies; imported by every module of the block
package v4au_pkg;

   localparam int FracBitsDefault = 16;
   localparam int QueueDepth      = 4;
   localparam logic [15:0] TolReset = 16'd7;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_SCALE = 3'd2,
      OP_DOT   = 3'd3,
      OP_NORM  = 3'd4,
      OP_HOMOG = 3'd5,
      OP_EQUAL = 3'd6
   } op_type;

   typedef enum logic [3:0] {
      K_ADD,
      K_SUB,
      K_SCALE,
      K_DOT,
      K_EQUAL,
      K_NORM,
      K_HOMOG,
      K_HFAULT,
      K_ZERO
   } kind_type;

   typedef enum logic [2:0] {
      SL_IDLE,
      SL_SQUARE,
      SL_SUM,
      SL_ROOT,
      SL_SETUP,
      SL_DIVIDE,
      SL_DONE
   } slow_state_type;

   typedef logic [3:0][31:0] vec_type;

   typedef struct packed {
      kind_type    kind;
      vec_type     a;
      vec_type     b;
      logic [31:0] s;
   } item_type;

   typedef struct packed {
      vec_type     r;
      logic [31:0] scalar;
      logic        is_equal;
      logic        divide_fault;
   } result_type;

   function automatic logic [31:0] sat32(input logic signed [67:0] v);
      logic [31:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -68'sh0_0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/v4au_req_if.sv -----
// v4au_req_if: request channel of the vec4 arithmetic unit
// valid/ready handshake with the operation code and operands; no dependencies
interface v4au_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] a_w;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] b_w;
   logic signed [31:0] scale_factor;

   modport source (output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   scale_factor, input ready);
   modport sink (input valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                 scale_factor, output ready);
endinterface

// ----- rtl/v4au_rsp_if.sv -----
// v4au_rsp_if: result channel of the vec4 arithmetic unit
// valid/ready handshake with the result vector, scalar and flags; no dependencies
interface v4au_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_x;
   logic signed [31:0] res_y;
   logic signed [31:0] res_z;
   logic signed [31:0] res_w;
   logic signed [31:0] scalar_result;
   logic               is_equal;
   logic               divide_fault;

   modport source (output valid, res_x, res_y, res_z, res_w, scalar_result, is_equal,
                   divide_fault, input ready);
   modport sink (input valid, res_x, res_y, res_z, res_w, scalar_result, is_equal,
                 divide_fault, output ready);
endinterface

// ----- rtl/v4au_front.sv -----
// v4au_front: accepts request beats, classifies them and queues them for the back end
// depends on v4au_pkg and v4au_req_if
module v4au_front import v4au_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   v4au_req_if.sink   req,
   output item_type   head,
   output logic       head_valid,
   input  logic       head_pop
);

   localparam int PtrBits   = $clog2(QueueDepth);
   localparam int CountBits = $clog2(QueueDepth + 1);

   item_type               mem_ff [QueueDepth];
   logic [PtrBits-1:0]     wr_ptr_ff;
   logic [PtrBits-1:0]     rd_ptr_ff;
   logic [CountBits-1:0]   count_ff;
   logic [CountBits-1:0]   count_in;
   item_type               cls;
   logic                   push;

   always_comb begin
      cls.a = {req.a_w, req.a_z, req.a_y, req.a_x};
      cls.b = {req.b_w, req.b_z, req.b_y, req.b_x};
      cls.s = req.scale_factor;
      case (op_type'(req.req_type))
         OP_ADD:   cls.kind = K_ADD;
         OP_SUB:   cls.kind = K_SUB;
         OP_SCALE: cls.kind = K_SCALE;
         OP_DOT:   cls.kind = K_DOT;
         OP_NORM:  cls.kind = K_NORM;
         OP_HOMOG: cls.kind = (req.a_w == 32'sd0) ? K_HFAULT : K_HOMOG;
         OP_EQUAL: cls.kind = K_EQUAL;
         default:  cls.kind = K_ZERO;
      endcase
   end

   assign req.ready  = (count_ff != CountBits'(QueueDepth));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (head_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/v4au_slow.sv -----
// v4au_slow: iterative normalize and homogenize unit (square root for normalize, then four dividers)
// depends on v4au_pkg
module v4au_slow import v4au_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  item_type   item,
   output logic       busy,
   output logic       done,
   input  logic       take,
   output result_type result
);

   localparam int DivW      = 32 + FRAC_BITS;
   localparam int RootSteps = 33;
   localparam int MaxSteps  = (DivW > RootSteps) ? DivW : RootSteps;
   localparam int CntW      = $clog2(MaxSteps + 1);

   slow_state_type      state_ff;
   slow_state_type      state_in;
   item_type            item_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [3:0][63:0]    sq_ff;
   logic [65:0]         rad_ff;
   logic [35:0]         srem_ff;
   logic [32:0]         root_ff;
   logic [32:0]         dvsr_ff;
   logic [3:0][33:0]    rem_ff;
   logic [3:0][DivW-1:0] dq_ff;
   logic [3:0]          neg_ff;
   logic                pass_ff;

   logic [3:0][31:0]    mag;
   logic [35:0]         srem_shift;
   logic [35:0]         trial;
   logic                root_ge;
   logic [3:0][33:0]    div_shift;
   logic [3:0]          div_ge;
   logic                last_root;
   logic                last_div;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = item_ff.a[i][31] ? (~item_ff.a[i] + 32'd1) : item_ff.a[i];
         div_shift[i] = {rem_ff[i][32:0], dq_ff[i][DivW-1]};
         div_ge[i]    = (div_shift[i] >= {1'b0, dvsr_ff});
      end
      srem_shift = {srem_ff[33:0], rad_ff[65:64]};
      trial      = {1'b0, root_ff, 2'b01};
      root_ge    = (srem_shift >= trial);
      last_root  = (cnt_ff == CntW'(RootSteps - 1));
      last_div   = (cnt_ff == CntW'(DivW - 1));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SL_IDLE: begin
            if (start) begin
               state_in = (item.kind == K_HOMOG) ? SL_SETUP : SL_SQUARE;
            end
         end
         SL_SQUARE: state_in = SL_SUM;
         SL_SUM:    state_in = SL_ROOT;
         SL_ROOT: begin
            if (last_root) begin
               state_in = SL_SETUP;
            end
         end
         SL_SETUP: begin
            state_in = (item_ff.kind == K_NORM && root_ff == '0) ? SL_DONE : SL_DIVIDE;
         end
         SL_DIVIDE: begin
            if (last_div) begin
               state_in = SL_DONE;
            end
         end
         SL_DONE: begin
            if (take) begin
               state_in = SL_IDLE;
            end
         end
         default: state_in = SL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         SL_IDLE: begin
            if (start) begin
               item_ff <= item;
            end
         end
         SL_SQUARE: begin
            for (int i = 0; i < 4; i++) begin
               sq_ff[i] <= 64'(mag[i]) * 64'(mag[i]);
            end
         end
         SL_SUM: begin
            rad_ff  <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]) + 66'(sq_ff[3]);
            srem_ff <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         SL_ROOT: begin
            srem_ff <= root_ge ? (srem_shift - trial) : srem_shift;
            root_ff <= {root_ff[31:0], root_ge};
            rad_ff  <= {rad_ff[63:0], 2'b00};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         SL_SETUP: begin
            pass_ff <= (item_ff.kind == K_NORM) && (root_ff == '0);
            dvsr_ff <= (item_ff.kind == K_NORM) ? root_ff : {1'b0, mag[3]};
            cnt_ff  <= '0;
            for (int i = 0; i < 4; i++) begin
               rem_ff[i] <= '0;
               dq_ff[i]  <= {mag[i], {FRAC_BITS{1'b0}}};
               neg_ff[i] <= (item_ff.kind == K_NORM) ? item_ff.a[i][31]
                                                     : (item_ff.a[i][31] ^ item_ff.a[3][31]);
            end
         end
         SL_DIVIDE: begin
            cnt_ff <= cnt_ff + 1'b1;
            for (int i = 0; i < 4; i++) begin
               rem_ff[i] <= div_ge[i] ? (div_shift[i] - {1'b0, dvsr_ff}) : div_shift[i];
               dq_ff[i]  <= {dq_ff[i][DivW-2:0], div_ge[i]};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.scalar       = '0;
      result.is_equal     = 1'b0;
      result.divide_fault = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (pass_ff) begin
            result.r[i] = item_ff.a[i];
         end else if (neg_ff[i]) begin
            result.r[i] = sat32(-$signed(68'(dq_ff[i])));
         end else begin
            result.r[i] = sat32($signed(68'(dq_ff[i])));
         end
      end
   end

   assign busy = (state_ff != SL_IDLE);
   assign done = (state_ff == SL_DONE);

endmodule

// ----- rtl/v4au_back.sv -----
// v4au_back: issue control, two-stage multiply pipeline and result register
// depends on v4au_pkg, v4au_rsp_if and v4au_slow
module v4au_back import v4au_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  item_type    head,
   input  logic        head_valid,
   output logic        head_pop,
   input  logic [15:0] tolerance,
   v4au_rsp_if.source  rsp
);

   localparam logic signed [67:0] Half = 68'sd1 <<< (FRAC_BITS - 1);

   logic                    e1_v_ff;
   item_type                e1_item_ff;
   logic signed [3:0][63:0] e1_prod_ff;
   logic                    out_v_ff;
   result_type              out_ff;

   logic        out_free;
   logic        e1_adv;
   logic        e1_load;
   logic        head_fast;
   logic        slow_start;
   logic        slow_busy;
   logic        slow_done;
   logic        slow_take;
   result_type  slow_res;
   result_type  e2_res;
   logic signed [67:0] dot_sum;
   logic signed [32:0] diff;
   logic [32:0]        diff_abs;

   assign head_fast  = (head.kind != K_NORM) && (head.kind != K_HOMOG);
   assign out_free   = !out_v_ff || rsp.ready;
   assign e1_adv     = e1_v_ff && out_free;
   assign e1_load    = head_valid && head_fast && !slow_busy && (!e1_v_ff || e1_adv);
   assign slow_start = head_valid && !head_fast && !slow_busy && !e1_v_ff;
   assign head_pop   = e1_load || slow_start;
   assign slow_take  = slow_done && out_free;

   v4au_slow #(.FRAC_BITS(FRAC_BITS)) u_slow (
      .clock  (clock),
      .reset  (reset),
      .start  (slow_start),
      .item   (head),
      .busy   (slow_busy),
      .done   (slow_done),
      .take   (slow_take),
      .result (slow_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
      end else if (e1_load) begin
         e1_v_ff <= 1'b1;
      end else if (e1_adv) begin
         e1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e1_load) begin
         e1_item_ff <= head;
         for (int i = 0; i < 4; i++) begin
            e1_prod_ff[i] <= $signed(head.a[i]) *
                             $signed((head.kind == K_SCALE) ? head.s : head.b[i]);
         end
      end
   end

   always_comb begin
      e2_res   = '0;
      dot_sum  = '0;
      diff     = '0;
      diff_abs = '0;
      case (e1_item_ff.kind)
         K_ADD: begin
            for (int i = 0; i < 4; i++) begin
               e2_res.r[i] = sat32(68'($signed(e1_item_ff.a[i])) +
                                   68'($signed(e1_item_ff.b[i])));
            end
         end
         K_SUB: begin
            for (int i = 0; i < 4; i++) begin
               e2_res.r[i] = sat32(68'($signed(e1_item_ff.a[i])) -
                                   68'($signed(e1_item_ff.b[i])));
            end
         end
         K_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               e2_res.r[i] = sat32((68'($signed(e1_prod_ff[i])) + Half) >>> FRAC_BITS);
            end
         end
         K_DOT: begin
            dot_sum = 68'($signed(e1_prod_ff[0])) + 68'($signed(e1_prod_ff[1])) +
                      68'($signed(e1_prod_ff[2])) + 68'($signed(e1_prod_ff[3]));
            e2_res.scalar = sat32((dot_sum + Half) >>> FRAC_BITS);
         end
         K_EQUAL: begin
            e2_res.is_equal = 1'b1;
            for (int i = 0; i < 4; i++) begin
               diff     = 33'($signed(e1_item_ff.a[i])) - 33'($signed(e1_item_ff.b[i]));
               diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
               if (diff_abs >= {17'd0, tolerance}) begin
                  e2_res.is_equal = 1'b0;
               end
            end
         end
         K_HFAULT: begin
            e2_res.divide_fault = 1'b1;
            for (int i = 0; i < 4; i++) begin
               if (e1_item_ff.a[i][31]) begin
                  e2_res.r[i] = 32'h8000_0000;
               end else if (e1_item_ff.a[i] != '0) begin
                  e2_res.r[i] = 32'h7FFF_FFFF;
               end else begin
                  e2_res.r[i] = '0;
               end
            end
         end
         default: begin
            e2_res = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= e1_adv || slow_take || (out_v_ff && !rsp.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (e1_adv) begin
         out_ff <= e2_res;
      end else if (slow_take) begin
         out_ff <= slow_res;
      end
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.res_x         = out_ff.r[0];
   assign rsp.res_y         = out_ff.r[1];
   assign rsp.res_z         = out_ff.r[2];
   assign rsp.res_w         = out_ff.r[3];
   assign rsp.scalar_result = out_ff.scalar;
   assign rsp.is_equal      = out_ff.is_equal;
   assign rsp.divide_fault  = out_ff.divide_fault;

`ifndef NO_ASSERTIONS
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue popped while empty");
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(e1_adv && slow_take))
      else $error("pipeline and iterative unit load result register together");
   a_slow_alone: assert property (@(posedge clock) disable iff (reset)
      slow_busy |-> !e1_v_ff)
      else $error("pipeline holds a beat while iterative unit is busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      slow_start |=> slow_busy)
      else $error("iterative unit did not take its beat");
`endif

endmodule

// ----- rtl/vec4_arith_unit.sv -----
// vec4_arith_unit: four-component Q16.16 vector unit, top level
// depends on v4au_pkg, v4au_req_if, v4au_rsp_if, v4au_front and v4au_back
//
// req_bus takes one beat per operation (code, vectors A and B, scale factor);
// rsp_bus returns exactly one result beat per request, in request order.
// csr_we/csr_wdata write the equality tolerance; write it only while idle.
// A four-entry queue separates the classifier from the execution back end.
// Add, sub, scale, dot, equal and homogenize by zero w: the beat passes the
// queue, the E1 multiply register and the result register, one beat per
// cycle sustained while rsp_bus is ready and the iterative unit is idle.
// Normalize runs the one-bit-per-cycle square root, then the four
// shared-divisor dividers; homogenize runs only the dividers; later beats
// wait behind it in the queue.
// A stalled rsp_bus holds its beat in the result register while the
// pipeline stops and the queue keeps taking requests until it fills.
// Reset empties the queue and pipeline and sets the tolerance to 7.
module vec4_arith_unit import v4au_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   v4au_req_if.sink    req_bus,
   v4au_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0] tol_ff;
   item_type    head;
   logic        head_valid;
   logic        head_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TolReset;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   v4au_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   v4au_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .tolerance  (tol_ff),
      .rsp        (rsp_bus)
   );

endmodule

// ----- sim/tb_pkg.sv -----
// tb_pkg: beat types for the vec4 arithmetic unit regression
// depends on v4au_pkg
package tb_pkg;
   import v4au_pkg::*;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
      logic signed [31:0] s;
   } req_beat_type;

   typedef struct {
      logic signed [31:0] r [4];
      logic signed [31:0] scalar;
      logic               eq;
      logic               fault;
   } rsp_beat_type;
endpackage

// ----- sim/testbench.sv -----
// testbench: self-checking regression of vec4_arith_unit
// depends on v4au_pkg, v4au_req_if, v4au_rsp_if, tb_pkg and the rtl top level
// directed and random operations with idle, stall and fill phases
module testbench;
   import v4au_pkg::*;
   import tb_pkg::*;

   localparam int Frac = 16;
   localparam int IdleLimit = 4000;
   localparam int DrainCycles = 200;

   logic clock;
   logic reset;
   logic csr_we;
   logic [15:0] csr_wdata;

   v4au_req_if req_bus ();
   v4au_rsp_if rsp_bus ();

   vec4_arith_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   req_beat_type pending_q [$];
   rsp_beat_type expected_q [$];
   logic [15:0] tolerance;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off;
   int errors;
   int idle_cycles;
   bit stim_done;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_fix(input logic signed [127:0] p);
      logic signed [127:0] q;
      q = (p + (128'sd1 <<< (Frac - 1))) >>> Frac;
      if (q > 128'sd2147483647) return 64'sd2147483647;
      if (q < -128'sd2147483648) return -64'sd2147483648;
      return longint'(q);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v = v - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function automatic rsp_beat_type vec_compute(input req_beat_type q);
      rsp_beat_type e;
      longint a [4];
      longint b [4];
      logic signed [127:0] acc;
      logic [64:0] sum;
      logic [63:0] len;
      longint d;
      for (int i = 0; i < 4; i++) begin
         e.r[i] = 0;
         a[i] = q.a[i];
         b[i] = q.b[i];
      end
      e.scalar = 0;
      e.eq = 0;
      e.fault = 0;
      case (q.op)
         OP_ADD: for (int i = 0; i < 4; i++) e.r[i] = sat(a[i] + b[i]);
         OP_SUB: for (int i = 0; i < 4; i++) e.r[i] = sat(a[i] - b[i]);
         OP_SCALE: for (int i = 0; i < 4; i++) e.r[i] = round_fix(a[i] * longint'(q.s));
         OP_DOT: begin
            acc = 0;
            for (int i = 0; i < 4; i++) acc += 128'(a[i] * b[i]);
            e.scalar = round_fix(acc);
         end
         OP_NORM: begin
            sum = 0;
            for (int i = 0; i < 4; i++) sum += 65'(64'(a[i] * a[i]));
            len = sum[64] ? 64'd1 << 32 : int_sqrt(sum[63:0]);
            for (int i = 0; i < 4; i++)
               e.r[i] = (len == 0) ? a[i] : sat((a[i] <<< Frac) / longint'(len));
         end
         OP_HOMOG: begin
            if (a[3] == 0) begin
               e.fault = 1;
               for (int i = 0; i < 4; i++)
                  e.r[i] = a[i] > 0 ? 32'h7fffffff : (a[i] < 0 ? 32'h80000000 : 0);
            end else begin
               for (int i = 0; i < 4; i++) e.r[i] = sat((a[i] <<< Frac) / a[3]);
            end
         end
         OP_EQUAL: begin
            e.eq = 1;
            for (int i = 0; i < 4; i++) begin
               d = a[i] - b[i];
               if (d < 0) d = -d;
               if (d >= longint'(tolerance)) e.eq = 0;
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_beat_type q;
            q = pending_q.pop_front();
            req_bus.valid <= 1;
            req_bus.req_type <= q.op;
            req_bus.a_x <= q.a[0];
            req_bus.a_y <= q.a[1];
            req_bus.a_z <= q.a[2];
            req_bus.a_w <= q.a[3];
            req_bus.b_x <= q.b[0];
            req_bus.b_y <= q.b[1];
            req_bus.b_z <= q.b[2];
            req_bus.b_w <= q.b[3];
            req_bus.scale_factor <= q.s;
         end else begin
            req_bus.valid <= 0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_bus.ready <= 0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_beat_type q;
            q.op = req_bus.req_type;
            q.a[0] = req_bus.a_x; q.a[1] = req_bus.a_y;
            q.a[2] = req_bus.a_z; q.a[3] = req_bus.a_w;
            q.b[0] = req_bus.b_x; q.b[1] = req_bus.b_y;
            q.b[2] = req_bus.b_z; q.b[3] = req_bus.b_w;
            q.s = req_bus.scale_factor;
            expected_q.push_back(vec_compute(q));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beat_type e;
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result beat x=%h", $time, rsp_bus.res_x);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_bus.res_x !== e.r[0] || rsp_bus.res_y !== e.r[1]
                   || rsp_bus.res_z !== e.r[2] || rsp_bus.res_w !== e.r[3]
                   || rsp_bus.scalar_result !== e.scalar
                   || rsp_bus.is_equal !== e.eq || rsp_bus.divide_fault !== e.fault) begin
                  $display("%0t mismatch exp %h %h %h %h s=%h eq=%b f=%b", $time,
                           e.r[0], e.r[1], e.r[2], e.r[3], e.scalar, e.eq, e.fault);
                  $display("%0t          got %h %h %h %h s=%h eq=%b f=%b", $time,
                           rsp_bus.res_x, rsp_bus.res_y, rsp_bus.res_z, rsp_bus.res_w,
                           rsp_bus.scalar_result, rsp_bus.is_equal, rsp_bus.divide_fault);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || hold_off > 0) begin
         idle_cycles <= 0;
      end else if (!stim_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] rand_val();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3: return $signed($urandom_range(1 << 20)) - (1 << 19);
         4: return $signed($urandom_range(1 << 17)) - (1 << 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(input logic [2:0] op, input logic signed [31:0] av [4],
                           input logic signed [31:0] bv [4], input logic signed [31:0] sv);
      req_beat_type q;
      q.op = op;
      q.a = av;
      q.b = bv;
      q.s = sv;
      pending_q.push_back(q);
   endtask

   task automatic add_random(input int n);
      logic signed [31:0] av [4];
      logic signed [31:0] bv [4];
      logic [2:0] op;
      for (int k = 0; k < n; k++) begin
         op = 3'($urandom_range(7));
         for (int i = 0; i < 4; i++) begin
            av[i] = rand_val();
            bv[i] = ($urandom_range(3) == 0)
                    ? av[i] + $signed($urandom_range(20)) - 10 : rand_val();
         end
         if (op == OP_HOMOG && $urandom_range(7) == 0) av[3] = 0;
         if (op == OP_NORM && $urandom_range(7) == 0) av = '{0, 0, 0, 0};
         add_item(op, av, bv, rand_val());
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_bus.valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_tolerance(input logic [15:0] v);
      @(negedge clock);
      csr_we = 1;
      csr_wdata = v;
      @(posedge clock);
      tolerance = v;
      @(negedge clock);
      csr_we = 0;
   endtask

   initial begin
      logic signed [31:0] mx [4];
      logic signed [31:0] mn [4];
      logic signed [31:0] z [4];
      logic signed [31:0] one [4];
      mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
      z = '{0, 0, 0, 0};
      one = '{32'sh10000, -32'sh20000, 32'sh8000, 32'sh10000};
      errors = 0;
      stim_done = 0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tolerance = TolReset;
      reset = 1;
      csr_we = 0;
      csr_wdata = 0;
      req_bus.valid = 0;
      req_bus.req_type = 0;
      {req_bus.a_x, req_bus.a_y, req_bus.a_z, req_bus.a_w} = 0;
      {req_bus.b_x, req_bus.b_y, req_bus.b_z, req_bus.b_w} = 0;
      req_bus.scale_factor = 0;
      rsp_bus.ready = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      add_item(OP_ADD, mx, mx, 0);
      add_item(OP_ADD, mn, mn, 0);
      add_item(OP_SUB, mx, mn, 0);
      add_item(OP_SUB, mn, mx, 0);
      add_item(OP_SCALE, mx, z, 32'sh7fffffff);
      add_item(OP_SCALE, mn, z, 32'sh80000000);
      add_item(OP_SCALE, one, z, 32'sh18000);
      add_item(OP_DOT, mx, mx, 0);
      add_item(OP_DOT, mn, mn, 0);
      add_item(OP_DOT, mx, mn, 0);
      add_item(OP_DOT, one, one, 0);
      add_item(OP_NORM, z, z, 0);
      add_item(OP_NORM, mn, z, 0);
      add_item(OP_NORM, one, z, 0);
      add_item(OP_NORM, '{1, 0, 0, 0}, z, 0);
      add_item(OP_HOMOG, '{5, -5, 0, 0}, z, 0);
      add_item(OP_HOMOG, mx, z, 0);
      add_item(OP_HOMOG, '{32'sh7fffffff, 32'sh80000000, 3, 1}, z, 0);
      add_item(OP_EQUAL, one, one, 0);
      add_item(OP_EQUAL, one, '{32'sh10006, -32'sh20006, 32'sh8000, 32'sh10000}, 0);
      add_item(OP_EQUAL, one, '{32'sh10007, -32'sh20000, 32'sh8000, 32'sh10000}, 0);
      add_item(OP_EQUAL, mx, mn, 0);
      add_item(3'd7, mx, mn, 32'sh7fffffff);
      drain();

      set_tolerance(16'hffff);
      add_random(105);
      drain();

      set_tolerance(0);
      send_idle_pct = 47;
      add_random(105);
      drain();

      set_tolerance(16'($urandom_range(1, 100)));
      send_idle_pct = 0;
      recv_stall_pct = 47;
      add_random(105);
      drain();

      set_tolerance(16'($urandom));
      send_idle_pct = 16;
      recv_stall_pct = 16;
      add_random(105);
      drain();

      // long receiver hold-off so the queue fills and the input stalls
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 300;
      add_random(105);
      drain();

      stim_done = 1;
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
